// ===== hw/rtl/rztp_pkg.sv =====
`default_nettype none

package rztp_pkg;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COS_Z    = 3'd0,
      CSR_SIN_Z    = 3'd1,
      CSR_COS_Y    = 3'd2,
      CSR_SIN_Y    = 3'd3,
      CSR_OFFSET_X = 3'd4,
      CSR_OFFSET_Y = 3'd5,
      CSR_OFFSET_Z = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rztp_rot2.sv =====
`default_nettype none

module rztp_rot2 #(
   parameter int A_WIDTH    = 32,
   parameter int C_WIDTH    = 18,
   parameter int FRAC_BITS  = 16,
   parameter int SIDE_WIDTH = 32,
   localparam int OUT_WIDTH = A_WIDTH + C_WIDTH + 1 - FRAC_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic signed [A_WIDTH-1:0]    in_a,
   input  wire logic signed [A_WIDTH-1:0]    in_b,
   input  wire logic signed [C_WIDTH-1:0]    coef_c,
   input  wire logic signed [C_WIDTH-1:0]    coef_s,
   input  wire logic        [SIDE_WIDTH-1:0] in_side,
   output logic                              out_valid,
   output logic signed [OUT_WIDTH-1:0]       out_p,
   output logic signed [OUT_WIDTH-1:0]       out_q,
   output logic        [SIDE_WIDTH-1:0]      out_side
);

   // out_p = round((a*c - b*s) / 2^F), out_q = round((a*s + b*c) / 2^F)

   localparam int PROD_WIDTH = A_WIDTH + C_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
      {{(SUM_WIDTH - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

   logic signed [PROD_WIDTH-1:0] prod_ac_in, prod_bs_in, prod_as_in, prod_bc_in;
   logic signed [PROD_WIDTH-1:0] prod_ac_ff, prod_bs_ff, prod_as_ff, prod_bc_ff;
   logic        [SIDE_WIDTH-1:0] side1_ff, side2_ff;
   logic                         valid1_ff, valid2_ff;
   logic signed [SUM_WIDTH-1:0]  sum_p_in, sum_q_in;
   logic signed [OUT_WIDTH-1:0]  p_ff, q_ff;

   always_comb begin
      prod_ac_in = PROD_WIDTH'(in_a) * PROD_WIDTH'(coef_c);
      prod_bs_in = PROD_WIDTH'(in_b) * PROD_WIDTH'(coef_s);
      prod_as_in = PROD_WIDTH'(in_a) * PROD_WIDTH'(coef_s);
      prod_bc_in = PROD_WIDTH'(in_b) * PROD_WIDTH'(coef_c);
   end

   always_ff @(posedge clock) begin
      prod_ac_ff <= prod_ac_in;
      prod_bs_ff <= prod_bs_in;
      prod_as_ff <= prod_as_in;
      prod_bc_ff <= prod_bc_in;
      side1_ff   <= in_side;
   end

   always_comb begin
      sum_p_in = SUM_WIDTH'(prod_ac_ff) - SUM_WIDTH'(prod_bs_ff) + ROUND_HALF;
      sum_q_in = SUM_WIDTH'(prod_as_ff) + SUM_WIDTH'(prod_bc_ff) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      p_ff     <= sum_p_in[SUM_WIDTH-1:FRAC_BITS];
      q_ff     <= sum_q_in[SUM_WIDTH-1:FRAC_BITS];
      side2_ff <= side1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_p     = p_ff;
   assign out_q     = q_ff;
   assign out_side  = side2_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rotate_zy_translate_point_core.sv =====
`default_nettype none

// Rotates a fixed-point 3D point about z, then about y, and adds a translation.
// Request channel: a transaction is taken at each rising edge with start high and
// busy low. The pipeline takes one point per clock, so busy stays low and a new
// point may follow in every cycle.
// Response channel: each result is shown for one cycle with rsp_valid high,
// once its request has passed through the stages listed below. The receiver
// cannot stall it, and results come out in request order.
// The five stages are the z-rotation multipliers, the z-rotation rounding adders,
// the y-rotation multipliers, the y-rotation rounding adders, and the offset add
// with saturation. rsp_clipped is set when any coordinate was saturated.
// Configuration: csr_we writes csr_data into the register at csr_index at once:
// 0 cos_z, 1 sin_z, 2 cos_y, 3 sin_y, 4..6 offset x, y, z. Other indexes are
// ignored. Write only while no transaction is in flight.
// Synchronous reset clears the pipeline valid bits and sets the rotation to the
// identity with zero offset.

module rotate_zy_translate_point_core #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   localparam int TRIG_WIDTH = FRAC_BITS + 2,
   localparam int CSR_WIDTH  = (COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [COORD_WIDTH-1:0]         req_in_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_in_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_in_z,
   output logic                                       rsp_valid,
   output logic signed [COORD_WIDTH-1:0]              rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]              rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]              rsp_out_z,
   output logic                                       rsp_clipped,
   input  wire logic                                  csr_we,
   input  wire logic [rztp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_WIDTH-1:0]                  csr_data
);

   localparam int LATENCY    = 5;
   localparam int ROTZ_WIDTH = COORD_WIDTH + TRIG_WIDTH + 1 - FRAC_BITS;
   localparam int ROTY_WIDTH = ROTZ_WIDTH + TRIG_WIDTH + 1 - FRAC_BITS;
   localparam int FIN_WIDTH  = ROTY_WIDTH + 1;
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = {2'b01, {FRAC_BITS{1'b0}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   logic signed [TRIG_WIDTH-1:0]  cos_z_ff, sin_z_ff, cos_y_ff, sin_y_ff;
   logic signed [COORD_WIDTH-1:0] offset_x_ff, offset_y_ff, offset_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_z_ff    <= TRIG_ONE;
         sin_z_ff    <= '0;
         cos_y_ff    <= TRIG_ONE;
         sin_y_ff    <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rztp_pkg::CSR_COS_Z:    cos_z_ff    <= csr_data[TRIG_WIDTH-1:0];
            rztp_pkg::CSR_SIN_Z:    sin_z_ff    <= csr_data[TRIG_WIDTH-1:0];
            rztp_pkg::CSR_COS_Y:    cos_y_ff    <= csr_data[TRIG_WIDTH-1:0];
            rztp_pkg::CSR_SIN_Y:    sin_y_ff    <= csr_data[TRIG_WIDTH-1:0];
            rztp_pkg::CSR_OFFSET_X: offset_x_ff <= csr_data[COORD_WIDTH-1:0];
            rztp_pkg::CSR_OFFSET_Y: offset_y_ff <= csr_data[COORD_WIDTH-1:0];
            rztp_pkg::CSR_OFFSET_Z: offset_z_ff <= csr_data[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic                         rotz_valid;
   logic signed [ROTZ_WIDTH-1:0] rot_x, rot_y;
   logic        [COORD_WIDTH-1:0] rotz_z;

   rztp_rot2 #(
      .A_WIDTH    (COORD_WIDTH),
      .C_WIDTH    (TRIG_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SIDE_WIDTH (COORD_WIDTH)
   ) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_a      (req_in_x),
      .in_b      (req_in_y),
      .coef_c    (cos_z_ff),
      .coef_s    (sin_z_ff),
      .in_side   (req_in_z),
      .out_valid (rotz_valid),
      .out_p     (rot_x),
      .out_q     (rot_y),
      .out_side  (rotz_z)
   );

   logic                         roty_valid;
   logic signed [ROTZ_WIDTH-1:0] rotz_z_ext;
   logic signed [ROTY_WIDTH-1:0] fin_z_rot, fin_x_rot;
   logic        [ROTZ_WIDTH-1:0] roty_y;

   assign rotz_z_ext = ROTZ_WIDTH'($signed(rotz_z));

   // With a = z and b = x: p = z*cy - x*sy is the new z, q = z*sy + x*cy the new x.
   rztp_rot2 #(
      .A_WIDTH    (ROTZ_WIDTH),
      .C_WIDTH    (TRIG_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SIDE_WIDTH (ROTZ_WIDTH)
   ) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rotz_valid),
      .in_a      (rotz_z_ext),
      .in_b      (rot_x),
      .coef_c    (cos_y_ff),
      .coef_s    (sin_y_ff),
      .in_side   (rot_y),
      .out_valid (roty_valid),
      .out_p     (fin_z_rot),
      .out_q     (fin_x_rot),
      .out_side  (roty_y)
   );

   function automatic logic [COORD_WIDTH:0] sat_fn(input logic signed [FIN_WIDTH-1:0] v);
      logic fits;
      fits = (v[FIN_WIDTH-1:COORD_WIDTH-1] ==
              {(FIN_WIDTH - COORD_WIDTH + 1){v[FIN_WIDTH-1]}});
      if (fits) begin
         return {1'b0, v[COORD_WIDTH-1:0]};
      end else if (v[FIN_WIDTH-1]) begin
         return {1'b1, SAT_MIN};
      end else begin
         return {1'b1, SAT_MAX};
      end
   endfunction

   logic signed [FIN_WIDTH-1:0] sum_x_in, sum_y_in, sum_z_in;
   logic        [COORD_WIDTH:0] sat_x_in, sat_y_in, sat_z_in;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                          clipped_ff, rsp_valid_ff;

   always_comb begin
      sum_x_in = FIN_WIDTH'(fin_x_rot) + FIN_WIDTH'(offset_x_ff);
      sum_y_in = FIN_WIDTH'($signed(roty_y)) + FIN_WIDTH'(offset_y_ff);
      sum_z_in = FIN_WIDTH'(fin_z_rot) + FIN_WIDTH'(offset_z_ff);
      sat_x_in = sat_fn(sum_x_in);
      sat_y_in = sat_fn(sum_y_in);
      sat_z_in = sat_fn(sum_z_in);
   end

   always_ff @(posedge clock) begin
      out_x_ff   <= sat_x_in[COORD_WIDTH-1:0];
      out_y_ff   <= sat_y_in[COORD_WIDTH-1:0];
      out_z_ff   <= sat_z_in[COORD_WIDTH-1:0];
      clipped_ff <= sat_x_in[COORD_WIDTH] | sat_y_in[COORD_WIDTH] | sat_z_in[COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= roty_valid;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = out_x_ff;
   assign rsp_out_y   = out_y_ff;
   assign rsp_out_z   = out_z_ff;
   assign rsp_clipped = clipped_ff;

`ifndef SYNTH
   a_accept_to_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction did not produce a response on time");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_out_x == SAT_MAX || rsp_out_x == SAT_MIN ||
          rsp_out_y == SAT_MAX || rsp_out_y == SAT_MIN ||
          rsp_out_z == SAT_MAX || rsp_out_z == SAT_MIN))
      else $error("clipped flag set without a saturated coordinate");

   a_no_response_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response strobe high right after reset");
`endif

endmodule

`default_nettype wire
